[rtl/core/aac_pkg.sv]
// Shared types and codes for the arena allocator with coalescing.
// Used by aac_core and arena_allocator_with_coalescing; depends on nothing.

package aac_pkg;

	// Request kind carried by the mode field.
	typedef enum logic {
		MODE_ALLOC = 1'b0,
		MODE_FREE  = 1'b1
	} mode_t;

	// Outcome codes returned with every result.
	typedef enum logic [1:0] {
		OC_SERVED  = 2'd0,
		OC_HEAP    = 2'd1,
		OC_IGNORED = 2'd2
	} outcome_t;

	// One result as handed from the sequencer to the output register.
	typedef struct packed {
		logic [31:0] data_address;
		outcome_t    outcome;
	} res_t;

endpackage

[rtl/core/aac_ram.sv]
// Generic simple dual-port RAM: one write port and one read port with registered data.
// Stand-alone; no package dependency.

module aac_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/core/aac_core.sv]
// Allocation and free sequencer: walks segment headers held in one aac_ram through its read and write ports.
// Depends on aac_pkg and aac_ram.

module aac_core #(
	parameter int ARENA_BYTES  = 4096,
	parameter int HEADER_BYTES = 12
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          mode,
	input  logic [31:0]   request_bytes,
	input  logic [31:0]   release_address,
	input  logic [31:0]   arena_base,
	output logic          idle,
	output logic          resp_valid,
	input  logic          resp_ready,
	output aac_pkg::res_t resp
);

	localparam int OFF_W = $clog2(ARENA_BYTES);
	localparam logic [OFF_W-1:0] HDR_O    = OFF_W'(HEADER_BYTES);
	localparam logic [OFF_W-1:0] LAST_O   = OFF_W'(ARENA_BYTES - 1);
	localparam logic [OFF_W:0]   ARENA_W1 = (OFF_W+1)'(ARENA_BYTES);
	localparam logic [31:0]      MAX_REQ  = 32'(ARENA_BYTES - HEADER_BYTES);

	typedef struct packed {
		logic             valid;
		logic             used;
		logic             has_prev;
		logic             has_next;
		logic [OFF_W-1:0] size;
		logic [OFF_W-1:0] prev;
		logic [OFF_W-1:0] next;
	} hdr_t;

	localparam int HDR_W = $bits(hdr_t);

	typedef enum logic [19:0] {
		S_CLR   = 20'h00001,
		S_IDLE  = 20'h00002,
		S_A0    = 20'h00004,
		S_ACHK  = 20'h00008,
		S_ASRV  = 20'h00010,
		S_AFIX  = 20'h00020,
		S_AWS   = 20'h00040,
		S_SKBEG = 20'h00080,
		S_SKFWD = 20'h00100,
		S_SKCHK = 20'h00200,
		S_F0    = 20'h00400,
		S_F1    = 20'h00800,
		S_FCHK  = 20'h01000,
		S_FPRV  = 20'h02000,
		S_FPFIX = 20'h04000,
		S_FNRD  = 20'h08000,
		S_FNXT  = 20'h10000,
		S_FNFIX = 20'h20000,
		S_FWB   = 20'h40000,
		S_RESP  = 20'h80000
	} state_t;

	state_t           state_q;
	logic [OFF_W-1:0] clr_q;
	logic [OFF_W-1:0] cf_q;
	logic             cf_valid_q;
	logic             mode_q;
	logic [31:0]      req_q;
	logic [31:0]      rel_q;
	logic [OFF_W-1:0] need_q;
	logic             sized_q;
	logic             fwd_q;
	logic [OFF_W-1:0] at_q;
	logic [OFF_W-1:0] node_q;
	logic [OFF_W-1:0] k_q;
	logic             merged_q;
	logic             bor_q;
	logic [31:0]      off_q;
	hdr_t             s_q;
	hdr_t             from_q;
	aac_pkg::res_t    res_q;

	logic             ram_we;
	logic [OFF_W-1:0] ram_waddr;
	hdr_t             ram_wdata;
	logic             ram_re;
	logic [OFF_W-1:0] ram_raddr;
	logic [HDR_W-1:0] ram_rdata;
	hdr_t             rd;

	hdr_t             init_hdr;
	hdr_t             rem_hdr;
	hdr_t             s_used;
	hdr_t             s_split;
	hdr_t             s_freed;
	hdr_t             fix_hdr;
	hdr_t             prv_merge;
	hdr_t             nxt_merge;
	logic             hit;
	logic             nxt_has;
	logic [OFF_W-1:0] nxt_at;
	logic [OFF_W:0]   split_at;
	logic [OFF_W:0]   tail;
	logic             split_ok;
	logic             req_bad;
	logic [OFF_W-1:0] free_node;
	logic [31:0]      serve_addr;

	assign rd = hdr_t'(ram_rdata);

	// Datapath shared by all states.
	always_comb begin
		init_hdr       = '0;
		init_hdr.valid = 1'b1;
		init_hdr.size  = OFF_W'(ARENA_BYTES - HEADER_BYTES);

		hit     = !rd.used && (!sized_q || (rd.size > need_q));
		nxt_has = fwd_q ? rd.has_next : rd.has_prev;
		nxt_at  = fwd_q ? rd.next : rd.prev;

		tail     = s_q.has_next ? {1'b0, s_q.next} : ARENA_W1;
		split_at = {1'b0, node_q} + {1'b0, HDR_O} + {1'b0, need_q};
		split_ok = (({1'b0, split_at} + {2'b00, HDR_O}) < {1'b0, tail}) &&
		           (split_at < ARENA_W1);

		rem_hdr          = '0;
		rem_hdr.valid    = 1'b1;
		rem_hdr.size     = OFF_W'(tail - split_at - {1'b0, HDR_O});
		rem_hdr.has_prev = 1'b1;
		rem_hdr.prev     = node_q;
		rem_hdr.has_next = s_q.has_next;
		rem_hdr.next     = s_q.next;

		s_used      = s_q;
		s_used.used = 1'b1;
		s_used.size = need_q;

		s_split          = s_used;
		s_split.has_next = 1'b1;
		s_split.next     = k_q;

		// The released header as it stands once its used flag is dropped.
		s_freed      = rd;
		s_freed.used = 1'b0;

		// Back-link repair for the neighbor after a split or merge.
		fix_hdr = rd;
		if (state_q == S_AFIX) begin
			fix_hdr.has_prev = 1'b1;
			fix_hdr.prev     = k_q;
		end else begin
			fix_hdr.prev = node_q;
		end

		prv_merge          = rd;
		prv_merge.size     = rd.size + s_q.size + HDR_O;
		prv_merge.has_next = s_q.has_next;
		prv_merge.next     = s_q.next;

		nxt_merge          = s_q;
		nxt_merge.size     = s_q.size + rd.size + HDR_O;
		nxt_merge.has_next = rd.has_next;
		nxt_merge.next     = rd.next;

		req_bad    = (req_q == 32'd0) || (req_q > MAX_REQ);
		free_node  = off_q[OFF_W-1:0] - HDR_O;
		serve_addr = arena_base + 32'(node_q) + 32'(HEADER_BYTES);
	end

	// Memory port control.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = node_q;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = node_q;
		case (state_q)
			S_CLR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = (clr_q == '0) ? init_hdr : '0;
			end
			S_A0: begin
				ram_re    = !req_bad && cf_valid_q;
				ram_raddr = cf_q;
			end
			S_ASRV: begin
				ram_we = 1'b1;
				if (split_ok) begin
					ram_waddr = split_at[OFF_W-1:0];
					ram_wdata = rem_hdr;
					ram_re    = s_q.has_next;
					ram_raddr = s_q.next;
				end else begin
					ram_waddr = node_q;
					ram_wdata = s_used;
				end
			end
			S_AFIX: begin
				ram_we    = 1'b1;
				ram_waddr = s_q.next;
				ram_wdata = fix_hdr;
			end
			S_AWS: begin
				ram_we    = 1'b1;
				ram_waddr = node_q;
				ram_wdata = s_split;
			end
			S_SKBEG: begin
				ram_re    = from_q.has_prev;
				ram_raddr = from_q.prev;
			end
			S_SKFWD: begin
				ram_re    = from_q.has_next;
				ram_raddr = from_q.next;
			end
			S_SKCHK: begin
				ram_re    = !hit && nxt_has;
				ram_raddr = nxt_at;
			end
			S_F1: begin
				ram_re    = (rel_q != 32'd0) && !bor_q && (off_q < 32'(ARENA_BYTES)) &&
				            (off_q >= 32'(HEADER_BYTES));
				ram_raddr = free_node;
			end
			S_FCHK: begin
				ram_re    = rd.valid && rd.used && rd.has_prev;
				ram_raddr = rd.prev;
			end
			S_FPRV: begin
				if (!rd.used) begin
					ram_we    = 1'b1;
					ram_waddr = node_q;
					ram_wdata = '0;
					ram_re    = s_q.has_next;
					ram_raddr = s_q.next;
				end
			end
			S_FPFIX, S_FNFIX: begin
				ram_we    = 1'b1;
				ram_waddr = at_q;
				ram_wdata = fix_hdr;
			end
			S_FNRD: begin
				ram_re    = s_q.has_next;
				ram_raddr = s_q.next;
			end
			S_FNXT: begin
				if (!rd.used) begin
					ram_we    = 1'b1;
					ram_waddr = at_q;
					ram_wdata = '0;
					ram_re    = rd.has_next;
					ram_raddr = rd.next;
				end
			end
			S_FWB: begin
				ram_we    = 1'b1;
				ram_waddr = node_q;
				ram_wdata = s_q;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLR;
			clr_q      <= '0;
			cf_q       <= '0;
			cf_valid_q <= 1'b1;
			sized_q    <= 1'b0;
			fwd_q      <= 1'b0;
			merged_q   <= 1'b0;
		end else begin
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_O) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						mode_q  <= mode;
						req_q   <= request_bytes;
						rel_q   <= release_address;
						state_q <= (mode == aac_pkg::MODE_FREE) ? S_F0 : S_A0;
					end
				end
				S_A0: begin
					need_q <= req_q[OFF_W-1:0];
					if (req_bad || !cf_valid_q) begin
						res_q   <= '{data_address: 32'd0, outcome: aac_pkg::OC_HEAP};
						state_q <= S_RESP;
					end else begin
						state_q <= S_ACHK;
					end
				end
				S_ACHK: begin
					from_q <= rd;
					if (need_q > rd.size) begin
						sized_q <= 1'b1;
						state_q <= S_SKBEG;
					end else begin
						node_q  <= cf_q;
						s_q     <= rd;
						state_q <= S_ASRV;
					end
				end
				S_ASRV: begin
					res_q <= '{data_address: serve_addr, outcome: aac_pkg::OC_SERVED};
					if (split_ok) begin
						k_q     <= split_at[OFF_W-1:0];
						state_q <= s_q.has_next ? S_AFIX : S_AWS;
					end else begin
						from_q  <= s_used;
						sized_q <= 1'b0;
						state_q <= S_SKBEG;
					end
				end
				S_AFIX: begin
					state_q <= S_AWS;
				end
				S_AWS: begin
					cf_q       <= k_q;
					cf_valid_q <= 1'b1;
					state_q    <= S_RESP;
				end
				S_SKBEG: begin
					fwd_q <= 1'b0;
					at_q  <= from_q.prev;
					state_q <= from_q.has_prev ? S_SKCHK : S_SKFWD;
				end
				S_SKFWD: begin
					fwd_q <= 1'b1;
					at_q  <= from_q.next;
					if (from_q.has_next) begin
						state_q <= S_SKCHK;
					end else if (sized_q) begin
						res_q   <= '{data_address: 32'd0, outcome: aac_pkg::OC_HEAP};
						state_q <= S_RESP;
					end else begin
						cf_q       <= '0;
						cf_valid_q <= 1'b0;
						state_q    <= S_RESP;
					end
				end
				S_SKCHK: begin
					if (hit) begin
						if (sized_q) begin
							node_q  <= at_q;
							s_q     <= rd;
							state_q <= S_ASRV;
						end else begin
							cf_q       <= at_q;
							cf_valid_q <= 1'b1;
							state_q    <= S_RESP;
						end
					end else if (nxt_has) begin
						at_q <= nxt_at;
					end else if (!fwd_q) begin
						state_q <= S_SKFWD;
					end else if (sized_q) begin
						res_q   <= '{data_address: 32'd0, outcome: aac_pkg::OC_HEAP};
						state_q <= S_RESP;
					end else begin
						cf_q       <= '0;
						cf_valid_q <= 1'b0;
						state_q    <= S_RESP;
					end
				end
				S_F0: begin
					{bor_q, off_q} <= {1'b0, rel_q} - {1'b0, arena_base};
					state_q <= S_F1;
				end
				S_F1: begin
					node_q <= free_node;
					if (rel_q == 32'd0) begin
						res_q   <= '{data_address: 32'd0, outcome: aac_pkg::OC_IGNORED};
						state_q <= S_RESP;
					end else if (bor_q || (off_q >= 32'(ARENA_BYTES))) begin
						res_q   <= '{data_address: 32'd0, outcome: aac_pkg::OC_HEAP};
						state_q <= S_RESP;
					end else if (off_q < 32'(HEADER_BYTES)) begin
						res_q   <= '{data_address: 32'd0, outcome: aac_pkg::OC_IGNORED};
						state_q <= S_RESP;
					end else begin
						state_q <= S_FCHK;
					end
				end
				S_FCHK: begin
					merged_q <= 1'b0;
					s_q      <= s_freed;
					if (!rd.valid || !rd.used) begin
						res_q   <= '{data_address: 32'd0, outcome: aac_pkg::OC_IGNORED};
						state_q <= S_RESP;
					end else begin
						state_q <= rd.has_prev ? S_FPRV : S_FNRD;
					end
				end
				S_FPRV: begin
					if (!rd.used) begin
						s_q      <= prv_merge;
						node_q   <= s_q.prev;
						merged_q <= 1'b1;
						at_q     <= s_q.next;
						state_q  <= s_q.has_next ? S_FPFIX : S_FNRD;
					end else begin
						state_q <= S_FNRD;
					end
				end
				S_FPFIX: begin
					state_q <= S_FNRD;
				end
				S_FNRD: begin
					at_q    <= s_q.next;
					state_q <= s_q.has_next ? S_FNXT : S_FWB;
				end
				S_FNXT: begin
					if (!rd.used) begin
						s_q      <= nxt_merge;
						merged_q <= 1'b1;
						at_q     <= rd.next;
						state_q  <= rd.has_next ? S_FNFIX : S_FWB;
					end else begin
						state_q <= S_FWB;
					end
				end
				S_FNFIX: begin
					state_q <= S_FWB;
				end
				S_FWB: begin
					if (!cf_valid_q || merged_q) begin
						cf_q       <= node_q;
						cf_valid_q <= 1'b1;
					end
					res_q   <= '{data_address: 32'd0, outcome: aac_pkg::OC_SERVED};
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (resp_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign idle       = (state_q == S_IDLE);
	assign resp_valid = (state_q == S_RESP);
	assign resp       = res_q;

	aac_ram #(
		.WIDTH(HDR_W),
		.DEPTH(ARENA_BYTES)
	) u_hdr_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

`ifndef SYNTH
	// The sequencer never reads a header in the cycle it writes the same one.
	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re && (ram_waddr == ram_raddr)))
		else $error("header read and write collide");

	// Only a served allocation carries an address.
	a_addr_only_served: assert property (@(posedge clk) disable iff (!arst_n)
		(resp_valid && (resp.outcome != aac_pkg::OC_SERVED)) |-> (resp.data_address == 32'd0))
		else $error("address on an unserved result");

	// A free never returns an address.
	a_free_no_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(resp_valid && (mode_q == aac_pkg::MODE_FREE)) |-> (resp.data_address == 32'd0))
		else $error("address on a free result");
`endif

endmodule

[rtl/core/arena_allocator_with_coalescing.sv]
// Top level of the arena allocator with coalescing: handshakes, base register, result register.
// Depends on aac_pkg and aac_core (which holds the header RAM).
//
//   channel   direction  handshake            payload
//   input     in         in_valid / in_stall   mode, request_bytes, release_address
//   result    out        out_valid / out_stall data_address, outcome
//   config    in         cfg_wen               cfg_wdata (arena_base)
//
// After reset the header memory is cleared one entry a cycle, all ARENA_BYTES entries (4096 by
// default), and no input transfer is taken meanwhile; configuration writes are taken always.
// An allocation visits the headers of the segment list one after another while searching,
// since all header accesses go through the one read port of the header RAM. Which neighbors
// of a freed segment exist and are merged decides which header writes and merges a free makes.
// One item is worked on at a time; in_stall is high from the transfer until the result has
// moved into the result register, which holds it until the receiver takes it.

module arena_allocator_with_coalescing #(
	parameter int ARENA_BYTES  = 4096,
	parameter int HEADER_BYTES = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        mode,
	input  logic [31:0] request_bytes,
	input  logic [31:0] release_address,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] data_address,
	output logic [1:0]  outcome,
	input  logic        cfg_wen,
	input  logic [31:0] cfg_wdata
);

	logic          base_valid_dummy_unused;
	logic [31:0]   arena_base_q;
	logic          core_idle;
	logic          resp_valid;
	logic          resp_ready;
	aac_pkg::res_t resp;
	logic          out_valid_q;
	aac_pkg::res_t out_q;

	assign base_valid_dummy_unused = 1'b0;

	// Base register; moving the arena keeps every segment as it is.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arena_base_q <= 32'd65536;
		end else if (cfg_wen) begin
			arena_base_q <= cfg_wdata;
		end
	end

	assign in_stall   = !core_idle || base_valid_dummy_unused;
	assign resp_ready = !out_valid_q || !out_stall;

	// Result register: loads when empty or when its content is being taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (resp_ready) begin
			out_valid_q <= resp_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (resp_ready && resp_valid) begin
			out_q <= resp;
		end
	end

	assign out_valid    = out_valid_q;
	assign data_address = out_q.data_address;
	assign outcome      = out_q.outcome;

	aac_core #(
		.ARENA_BYTES (ARENA_BYTES),
		.HEADER_BYTES(HEADER_BYTES)
	) u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (in_valid && !in_stall),
		.mode           (mode),
		.request_bytes  (request_bytes),
		.release_address(release_address),
		.arena_base     (arena_base_q),
		.idle           (core_idle),
		.resp_valid     (resp_valid),
		.resp_ready     (resp_ready),
		.resp           (resp)
	);

endmodule
